/* rtl/core/rim_pkg.sv */
// ----------------------------------------------------------------------------
// rim_pkg
// Shared constants, register codes and types of the region interior marker.
// ----------------------------------------------------------------------------
package rim_pkg;

    localparam int CFG_BITS       = 13;
    localparam int CFG_IDX_BITS   = 2;
    localparam int MAX_HEIGHT     = 4096;
    localparam int HGT_BITS       = $clog2(MAX_HEIGHT + 1);
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_INDEX_BITS = 8;
    localparam int RST_WIDTH      = 640;
    localparam int RST_HEIGHT     = 480;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // Per-item control handed from the sequencer to the window stage
    typedef struct packed {
        logic emit;       // item produces a result for the target pixel
        logic has_left;
        logic has_right;
        logic has_above;
        logic has_below;
        logic last;       // target is the last pixel of the frame
        logic narrow;     // frame is one pixel wide
    } rim_step_t;

endpackage

/* rtl/core/rim_ctrl.sv */
// ----------------------------------------------------------------------------
// rim_ctrl
// Configuration registers and frame sequencer: input column/row counters,
// drain phase, result lag and target pixel position.
// ----------------------------------------------------------------------------
module rim_ctrl
    import rim_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_BITS-1:0]           cfg_wdata,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_func,
    output logic                          step_load,
    output logic                          pix_wr,
    output logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
    output logic [$clog2(MAX_WIDTH)-1:0]  tgt_col,
    output rim_step_t                     step
);

    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int AB    = $clog2(MAX_WIDTH);
    localparam int LB    = $clog2(MAX_WIDTH + 2);
    localparam int HB    = HGT_BITS;
    localparam int RST_W = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;

    logic [WB-1:0] width_reg, width_next;
    logic [HB-1:0] height_reg, height_next;
    logic [AB-1:0] col_reg, col_next;
    logic [HB-1:0] row_reg, row_next;
    logic [WB-1:0] drain_reg, drain_next;
    logic          draining_reg, draining_next;
    logic [LB-1:0] lag_reg, lag_next;
    logic [AB-1:0] tcol_reg, tcol_next;
    logic [HB-1:0] trow_reg, trow_next;

    logic        match;
    logic        col_wrap;
    logic        tcol_wrap;
    logic        emit;
    logic        restart;
    logic [31:0] wdata32;
    logic [31:0] wval;
    logic [31:0] hval;

    always_comb begin
        wdata32 = 32'(cfg_wdata);
        if (wdata32 == 32'd0) begin
            wval = 32'd1;
            hval = 32'd1;
        end else begin
            wval = (wdata32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : wdata32;
            hval = (wdata32 > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : wdata32;
        end
    end

    always_comb begin
        match     = draining_reg ? (s_func == FUNC_DRAIN) : (s_func == FUNC_PIXEL);
        step_load = s_valid && s_ready && match;
        pix_wr    = step_load && !draining_reg;
        col_wrap  = (32'(col_reg) + 32'd1 == 32'(width_reg));
        tcol_wrap = (32'(tcol_reg) + 32'd1 == 32'(width_reg));
        emit      = (32'(lag_reg) == 32'(width_reg) + 32'd1);

        width_next    = width_reg;
        height_next   = height_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        drain_next    = drain_reg;
        draining_next = draining_reg;
        lag_next      = lag_reg;
        tcol_next     = tcol_reg;
        trow_next     = trow_reg;
        restart       = 1'b0;

        if (cfg_wr_en) begin
            if (cfg_index == REG_FRAME_WIDTH) begin
                width_next = WB'(wval);
                restart    = 1'b1;
            end else if (cfg_index == REG_FRAME_HEIGHT) begin
                height_next = HB'(hval);
                restart     = 1'b1;
            end
        end else if (step_load) begin
            if (emit) begin
                if (tcol_wrap) begin
                    tcol_next = '0;
                    trow_next = trow_reg + HB'(1);
                end else begin
                    tcol_next = tcol_reg + AB'(1);
                end
            end else begin
                lag_next = lag_reg + LB'(1);
            end
            col_next = col_wrap ? '0 : col_reg + AB'(1);
            if (!draining_reg) begin
                if (col_wrap) begin
                    if (32'(row_reg) + 32'd1 == 32'(height_reg)) begin
                        row_next      = '0;
                        drain_next    = '0;
                        draining_next = 1'b1;
                    end else begin
                        row_next = row_reg + HB'(1);
                    end
                end
            end else if (drain_reg == width_reg) begin
                // last flush item: expect the next frame
                restart = 1'b1;
            end else begin
                drain_next = drain_reg + WB'(1);
            end
        end

        if (restart) begin
            col_next      = '0;
            row_next      = '0;
            drain_next    = '0;
            draining_next = 1'b0;
            lag_next      = '0;
            tcol_next     = '0;
            trow_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= WB'(RST_W);
            height_reg   <= HB'(RST_HEIGHT);
            col_reg      <= '0;
            row_reg      <= '0;
            drain_reg    <= '0;
            draining_reg <= 1'b0;
            lag_reg      <= '0;
            tcol_reg     <= '0;
            trow_reg     <= '0;
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            drain_reg    <= drain_next;
            draining_reg <= draining_next;
            lag_reg      <= lag_next;
            tcol_reg     <= tcol_next;
            trow_reg     <= trow_next;
        end
    end

    always_comb begin
        rd_addr        = col_reg;
        tgt_col        = tcol_reg;
        step.emit      = emit;
        step.has_left  = (tcol_reg != '0);
        step.has_right = !tcol_wrap;
        step.has_above = (trow_reg != '0);
        step.has_below = (32'(trow_reg) + 32'd1 < 32'(height_reg));
        step.last      = tcol_wrap && (32'(trow_reg) + 32'd1 == 32'(height_reg));
        step.narrow    = (width_reg == WB'(1));
    end

endmodule

/* rtl/core/rim_linebuf.sv */
// ----------------------------------------------------------------------------
// rim_linebuf
// Two column-addressed line memories: original indices of the previous row
// and marked results (index plus interior flag) of the row above the target.
// ----------------------------------------------------------------------------
module rim_linebuf
    import rim_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
    input  logic                          pix_wr,
    input  logic [INDEX_BITS-1:0]         pix_data,
    input  logic                          fin_wr,
    input  logic [$clog2(MAX_WIDTH)-1:0]  fin_addr,
    input  logic [INDEX_BITS:0]           fin_data,
    output logic [INDEX_BITS-1:0]         orig_q,
    output logic [INDEX_BITS:0]           fin_q
);

    logic [INDEX_BITS-1:0] orig_mem [MAX_WIDTH];
    logic [INDEX_BITS:0]   fin_mem  [MAX_WIDTH];

    logic [INDEX_BITS-1:0] orig_q_reg;
    logic [INDEX_BITS:0]   fin_q_reg;
    logic [INDEX_BITS:0]   byp_data_reg;
    logic                  byp_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            orig_q_reg   <= orig_mem[rd_addr];
            fin_q_reg    <= fin_mem[rd_addr];
            byp_data_reg <= fin_data;
        end
        if (pix_wr) begin
            orig_mem[rd_addr] <= pix_data;
        end
        if (fin_wr) begin
            fin_mem[fin_addr] <= fin_data;
        end
    end

    // Forward a result written in the same cycle as the read of its entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else if (rd_en) begin
            byp_reg <= fin_wr && (fin_addr == rd_addr);
        end
    end

    assign orig_q = orig_q_reg;
    assign fin_q  = byp_reg ? byp_data_reg : fin_q_reg;

endmodule

/* rtl/core/rim_window.sv */
// ----------------------------------------------------------------------------
// rim_window
// 3x3 window registers, interior test, result write-back and output register.
// ----------------------------------------------------------------------------
module rim_window
    import rim_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_load,
    input  rim_step_t                     step_in,
    input  logic [INDEX_BITS-1:0]         pix_in,
    input  logic [$clog2(MAX_WIDTH)-1:0]  tcol_in,
    input  logic [INDEX_BITS-1:0]         orig_q,
    input  logic [INDEX_BITS:0]           fin_q,
    output logic                          s_ready,
    output logic                          fin_wr,
    output logic [$clog2(MAX_WIDTH)-1:0]  fin_addr,
    output logic [INDEX_BITS:0]           fin_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [INDEX_BITS-1:0]         m_region_index,
    output logic                          m_interior,
    output logic                          m_frame_end
);

    localparam int AB = $clog2(MAX_WIDTH);
    localparam int IB = INDEX_BITS;

    logic          s1_valid_reg, s1_valid_next;
    rim_step_t     s1_step_reg;
    logic [IB-1:0] s1_pix_reg;
    logic [AB-1:0] s1_col_reg;

    logic [IB-1:0] ctr_reg;
    logic [IB-1:0] left_idx_reg;
    logic          left_flag_reg;
    logic [IB-1:0] bel1_reg;
    logic [IB-1:0] bel2_reg;
    logic [IB:0]   abv1_reg;
    logic [IB:0]   abv2_reg;

    logic          out_valid_reg, out_valid_next;
    logic [IB-1:0] out_idx_reg;
    logic          out_int_reg;
    logic          out_end_reg;

    logic          go;
    logic          ok;
    logic [IB:0]   above_c;
    logic          ok_mid;
    logic          ok_below;
    logic          ok_above;

    // Earlier neighbor matches when already marked interior or same index
    function automatic logic early_ok(input logic [IB:0] e, input logic [IB-1:0] c);
        return e[IB] || (e[IB-1:0] == c);
    endfunction

    always_comb begin
        go      = s1_valid_reg && (!s1_step_reg.emit || !out_valid_reg || m_ready);
        s_ready = !s1_valid_reg || go;

        // one pixel wide: the pixel above is the previous target
        above_c = s1_step_reg.narrow ? {left_flag_reg, left_idx_reg} : abv1_reg;

        ok_mid = (!s1_step_reg.has_left || early_ok({left_flag_reg, left_idx_reg}, ctr_reg))
              && (!s1_step_reg.has_right || orig_q == ctr_reg);
        ok_below = !s1_step_reg.has_below
                || ((bel1_reg == ctr_reg)
                    && (!s1_step_reg.has_left || bel2_reg == ctr_reg)
                    && (!s1_step_reg.has_right || s1_pix_reg == ctr_reg));
        ok_above = !s1_step_reg.has_above
                || (early_ok(above_c, ctr_reg)
                    && (!s1_step_reg.has_left || early_ok(abv2_reg, ctr_reg))
                    && (!s1_step_reg.has_right || early_ok(fin_q, ctr_reg)));
        ok = ok_mid && ok_below && ok_above;

        fin_wr   = go && s1_step_reg.emit;
        fin_addr = s1_col_reg;
        fin_data = {ok, ctr_reg};

        if (step_load) begin
            s1_valid_next = 1'b1;
        end else if (go) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        if (go && s1_step_reg.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_load) begin
            s1_step_reg <= step_in;
            s1_pix_reg  <= pix_in;
            s1_col_reg  <= tcol_in;
        end
        // advance the window by one item
        if (go) begin
            ctr_reg       <= orig_q;
            left_idx_reg  <= ctr_reg;
            left_flag_reg <= ok;
            bel1_reg      <= s1_pix_reg;
            bel2_reg      <= bel1_reg;
            abv1_reg      <= fin_q;
            abv2_reg      <= abv1_reg;
        end
        if (go && s1_step_reg.emit) begin
            out_idx_reg <= ctr_reg;
            out_int_reg <= ok;
            out_end_reg <= s1_step_reg.last;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_region_index = out_idx_reg;
    assign m_interior     = out_int_reg;
    assign m_frame_end    = out_end_reg;

endmodule

/* rtl/core/region_interior_marker_core.sv */
// Result path: the item that completes a pixel's 3x3 window, frame_width+1 items after the
// pixel, loads the window stage register; when that stage advances, the pixel's result is
// registered in the output register, from which it transfers out.
// Throughput: one item per cycle, set by one read and one write per cycle on
// each column line memory; back-pressure on the result side stalls the input.
// Reset: synchronous, active low; width 640, height 480, counters cleared.
// Line memories are not cleared; only entries written in the current frame are used.
// ----------------------------------------------------------------------------
// region_interior_marker_core
// Marks each pixel of a raster stream of region indices as interior when all
// existing 8-neighbors match, scanning in place with two line memories.
// ----------------------------------------------------------------------------
module region_interior_marker_core
    import rim_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_func,
    input  logic [INDEX_BITS-1:0]   s_pixel_index,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [INDEX_BITS-1:0]   m_region_index,
    output logic                    m_interior,
    output logic                    m_frame_end
);

    localparam int AB = $clog2(MAX_WIDTH);

    logic                  step_load;
    logic                  pix_wr;
    logic [AB-1:0]         rd_addr;
    logic [AB-1:0]         tgt_col;
    rim_step_t             step;
    logic                  fin_wr;
    logic [AB-1:0]         fin_addr;
    logic [INDEX_BITS:0]   fin_data;
    logic [INDEX_BITS-1:0] orig_q;
    logic [INDEX_BITS:0]   fin_q;

    rim_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .step_load (step_load),
        .pix_wr    (pix_wr),
        .rd_addr   (rd_addr),
        .tgt_col   (tgt_col),
        .step      (step)
    );

    rim_linebuf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .INDEX_BITS (INDEX_BITS)
    ) u_linebuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (step_load),
        .rd_addr  (rd_addr),
        .pix_wr   (pix_wr),
        .pix_data (s_pixel_index),
        .fin_wr   (fin_wr),
        .fin_addr (fin_addr),
        .fin_data (fin_data),
        .orig_q   (orig_q),
        .fin_q    (fin_q)
    );

    rim_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .INDEX_BITS (INDEX_BITS)
    ) u_window (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_load      (step_load),
        .step_in        (step),
        .pix_in         (s_pixel_index),
        .tcol_in        (tgt_col),
        .orig_q         (orig_q),
        .fin_q          (fin_q),
        .s_ready        (s_ready),
        .fin_wr         (fin_wr),
        .fin_addr       (fin_addr),
        .fin_data       (fin_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_region_index (m_region_index),
        .m_interior     (m_interior),
        .m_frame_end    (m_frame_end)
    );

endmodule

/* rtl/core/rim_checker.sv */
// ----------------------------------------------------------------------------
// rim_checker
// Port-level checks of the region interior marker, bound to the top level.
// ----------------------------------------------------------------------------
module rim_checker
    import rim_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [INDEX_BITS-1:0] m_region_index,
    input logic                  m_interior,
    input logic                  m_frame_end
);

    // Hold a pending result until its transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            ($stable(m_region_index) && $stable(m_interior) && $stable(m_frame_end)))
        else $error("result payload changed while stalled");

    // Input is held off only by a stalled result
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without result back-pressure");

    // A fresh result follows an earlier input transfer through the window stage and output registers
    a_out_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a matching input transfer");

endmodule

bind region_interior_marker_core rim_checker #(
    .INDEX_BITS (INDEX_BITS)
) u_rim_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_region_index (m_region_index),
    .m_interior     (m_interior),
    .m_frame_end    (m_frame_end)
);

/* tb/sv/region_interior_marker_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_interior_marker_core_tb
// Streams frames of region indices through the core. An in-order model of
// the in-place 3x3 interior scan predicts every result, and the results are
// checked field by field in arrival order. Directed frames cover the corner
// cases, then random frames of random shape run under changing back-pressure.
// ----------------------------------------------------------------------------
module region_interior_marker_core_tb;
    import rim_pkg::*;

    localparam int IDX_W        = DEF_INDEX_BITS;
    localparam int RING_DEPTH   = 2 * DEF_MAX_WIDTH + 2;
    localparam int SETTLE_CYC   = 8;
    localparam int RANDOM_ITEMS = 950;

    // indexes with no register behind them
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_2 = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_3 = CFG_IDX_BITS'(3);

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic             func;
        logic [IDX_W-1:0] pix;
    } px_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] region;
        logic             interior;
        logic             frame_end;
    } mark_t;

    logic                    aclk;
    logic                    aresetn       = 1'b0;
    logic                    cfg_wr_en     = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index     = '0;
    logic [CFG_BITS-1:0]     cfg_wdata     = '0;
    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic                    s_func        = FUNC_PIXEL;
    logic [IDX_W-1:0]        s_pixel_index = '0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic [IDX_W-1:0]        m_region_index;
    logic                    m_interior;
    logic                    m_frame_end;

    px_item_t    pixel_q[$];
    mark_t       expected_marks[$];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;

    // scan state of the model
    logic [IDX_W:0]      ring[RING_DEPTH];
    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;
    int unsigned         col_cnt;
    int unsigned         row_cnt;
    int unsigned         drain_cnt;
    bit                  draining;

    region_interior_marker_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_pixel_index  (s_pixel_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_region_index (m_region_index),
        .m_interior     (m_interior),
        .m_frame_end    (m_frame_end)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int unsigned clamp_dim(logic [CFG_BITS-1:0] v, int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return 32'(v);
    endfunction

    function automatic int unsigned ring_back(int unsigned t, int unsigned d);
        return (t % RING_DEPTH + RING_DEPTH - d) % RING_DEPTH;
    endfunction

    function automatic int unsigned ring_fwd(int unsigned t, int unsigned d);
        return (t % RING_DEPTH + d) % RING_DEPTH;
    endfunction

    // earlier neighbor: already interior, or same index
    function automatic bit early_match(logic [IDX_W:0] e, logic [IDX_W-1:0] c);
        return e[IDX_W] || (e[IDX_W-1:0] == c);
    endfunction

    function automatic void restart_scan();
        col_cnt   = 0;
        row_cnt   = 0;
        drain_cnt = 0;
        draining  = 1'b0;
    endfunction

    // Advance the scan by one accepted item and queue the mark it releases.
    function automatic void predict_marks(logic func, logic [IDX_W-1:0] pix);
        int unsigned      w, h, total, k, t, tx, ty, ts;
        logic [IDX_W-1:0] c;
        bit               has_l, has_r, ok;
        mark_t            m;
        w     = clamp_dim(width_reg, DEF_MAX_WIDTH);
        h     = clamp_dim(height_reg, MAX_HEIGHT);
        total = w * h;
        if ((func == FUNC_DRAIN) != draining)
            return;
        k = draining ? total + drain_cnt : row_cnt * w + col_cnt;
        if (k >= w + 1) begin
            t     = k - w - 1;
            tx    = t % w;
            ty    = t / w;
            ts    = t % RING_DEPTH;
            c     = ring[ts][IDX_W-1:0];
            has_l = tx > 0;
            has_r = tx + 1 < w;
            ok    = 1'b1;
            if (has_l && !early_match(ring[ring_back(t, 1)], c))
                ok = 1'b0;
            if (has_r && ring[ring_fwd(t, 1)][IDX_W-1:0] != c)
                ok = 1'b0;
            if (ty + 1 < h) begin
                if (ring[ring_fwd(t, w)][IDX_W-1:0] != c)
                    ok = 1'b0;
                if (has_l && ring[ring_fwd(t, w - 1)][IDX_W-1:0] != c)
                    ok = 1'b0;
                // below-right neighbor is the item in hand
                if (has_r && pix != c)
                    ok = 1'b0;
            end
            if (ty > 0) begin
                if (!early_match(ring[ring_back(t, w)], c))
                    ok = 1'b0;
                if (has_l && !early_match(ring[ring_back(t, w + 1)], c))
                    ok = 1'b0;
                if (has_r && !early_match(ring[ring_back(t, w - 1)], c))
                    ok = 1'b0;
            end
            if (ok)
                ring[ts][IDX_W] = 1'b1;
            m.region    = c;
            m.interior  = ok;
            m.frame_end = (t == total - 1);
            expected_marks.insert(expected_marks.size(), m);
        end
        if (func == FUNC_PIXEL) begin
            ring[k % RING_DEPTH] = {1'b0, pix};
            col_cnt++;
            if (col_cnt >= w) begin
                col_cnt = 0;
                row_cnt++;
                if (row_cnt >= h) begin
                    row_cnt   = 0;
                    drain_cnt = 0;
                    draining  = 1'b1;
                end
            end
        end else begin
            drain_cnt++;
            if (drain_cnt >= w + 1) begin
                drain_cnt = 0;
                draining  = 1'b0;
            end
        end
    endfunction

    function automatic void push_item(logic func, logic [IDX_W-1:0] pix);
        px_item_t it;
        it.func = func;
        it.pix  = pix;
        pixel_q.insert(pixel_q.size(), it);
    endfunction

    // Queue items [first, last) of a frame sequence (pixels, then drains),
    // sprinkled with stray items that the core has to ignore.
    function automatic int unsigned push_frame_span(int unsigned w, int unsigned h,
                                                    int unsigned first, int unsigned last);
        int unsigned      s, x, mode, split;
        logic [IDX_W-1:0] base, alt, v;
        mode  = $urandom_range(3);
        base  = IDX_W'($urandom_range(255));
        alt   = IDX_W'($urandom_range(255));
        split = $urandom_range(w);
        for (s = first; s < last; s++) begin
            if ($urandom_range(24) == 0)
                push_item(s < w * h ? FUNC_DRAIN : FUNC_PIXEL, IDX_W'($urandom_range(255)));
            if (s < w * h) begin
                x = s % w;
                case (mode)
                    0: v = ($urandom_range(11) == 0) ? alt : base;
                    1: v = (x >= split) ? alt : base;
                    2: v = IDX_W'($urandom_range(255));
                    default: v = $urandom_range(1) ? alt : base;
                endcase
                push_item(FUNC_PIXEL, v);
            end else begin
                push_item(FUNC_DRAIN, IDX_W'($urandom_range(255)));
            end
        end
        return last - first;
    endfunction

    function automatic void set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default:   begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endfunction

    // Hold until every item is transferred and every mark is back, then settle.
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (pixel_q.size() != 0 || s_valid || expected_marks.size() != 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_BITS'(val);
        if (idx == REG_FRAME_WIDTH) begin
            width_reg = CFG_BITS'(val);
            restart_scan();
        end else if (idx == REG_FRAME_HEIGHT) begin
            height_reg = CFG_BITS'(val);
            restart_scan();
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_frame(int unsigned w, int unsigned h);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // input side: present queued items, predict on each transfer
    always @(posedge aclk) begin
        px_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_marks(s_func, s_pixel_index);
            if (!s_valid || s_ready) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pixel_q.pop_front();
                    s_valid       <= 1'b1;
                    s_func        <= nxt.func;
                    s_pixel_index <= nxt.pix;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side: random stall, compare each transfer with the oldest mark
    always @(posedge aclk) begin
        mark_t exp_m;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_marks.size() == 0) begin
                    $display("%0t: unexpected result region_index=%0d interior=%0b frame_end=%0b",
                             $time, m_region_index, m_interior, m_frame_end);
                    error_count++;
                end else begin
                    exp_m = expected_marks.pop_front();
                    if (m_region_index !== exp_m.region) begin
                        $display("%0t: region_index expected %0d actual %0d",
                                 $time, exp_m.region, m_region_index);
                        error_count++;
                    end
                    if (m_interior !== exp_m.interior) begin
                        $display("%0t: interior expected %0b actual %0b",
                                 $time, exp_m.interior, m_interior);
                        error_count++;
                    end
                    if (m_frame_end !== exp_m.frame_end) begin
                        $display("%0t: frame_end expected %0b actual %0b",
                                 $time, exp_m.frame_end, m_frame_end);
                        error_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : stimulus
        int unsigned w, h, we, he, n, cut, kind, counted;
        foreach (ring[i])
            ring[i] = '0;
        width_reg  = CFG_BITS'(RST_WIDTH);
        height_reg = CFG_BITS'(RST_HEIGHT);
        restart_scan();
        counted = 0;
        set_idle(IDLE_NONE);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset geometry: a stray drain, then early pixels that release nothing
        push_item(FUNC_DRAIN, 8'h00);
        push_item(FUNC_PIXEL, 8'h00);
        push_item(FUNC_PIXEL, 8'hFF);

        // zero sizes act as a single pixel; a pixel while draining is ignored
        set_frame(0, 0);
        push_item(FUNC_PIXEL, 8'hFF);
        push_item(FUNC_PIXEL, 8'h00);
        push_item(FUNC_DRAIN, 8'hFF);
        push_item(FUNC_DRAIN, 8'h00);
        push_item(FUNC_PIXEL, 8'h00);
        push_item(FUNC_DRAIN, 8'h00);
        push_item(FUNC_DRAIN, 8'hFF);

        set_frame(3, 2);
        push_item(FUNC_PIXEL, 8'h00);
        push_item(FUNC_PIXEL, 8'h00);
        push_item(FUNC_PIXEL, 8'h00);
        push_item(FUNC_PIXEL, 8'h00);
        push_item(FUNC_PIXEL, 8'h00);
        push_item(FUNC_PIXEL, 8'hFF);
        repeat (4) push_item(FUNC_DRAIN, 8'h5A);

        // writes to unused indexes mid-frame must not restart the scan
        set_frame(3, 3);
        void'(push_frame_span(3, 3, 0, 5));
        wait_idle();
        write_reg(REG_SPARE_2, 8191);
        write_reg(REG_SPARE_3, 0);
        void'(push_frame_span(3, 3, 5, 13));

        // a width write mid-frame drops the partial frame
        set_frame(2, 2);
        void'(push_frame_span(2, 2, 0, 3));
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 2);
        void'(push_frame_span(2, 2, 0, 7));

        // oversized registers clamp to the maximum; run the head of each frame
        set_idle(IDLE_BOTH);
        set_frame(8191, 1);
        void'(push_frame_span(DEF_MAX_WIDTH, 1, 0, 48));
        set_idle(IDLE_RECV);
        set_frame(0, 8191);
        void'(push_frame_span(1, MAX_HEIGHT, 0, 96));

        while (counted < RANDOM_ITEMS) begin
            wait_idle();
            set_idle(idle_mode_t'($urandom_range(3)));
            w = $urandom_range(9) == 0 ? $urandom_range(40) : $urandom_range(1, 8);
            h = $urandom_range(6);
            set_frame(w, h);
            we   = clamp_dim(CFG_BITS'(w), DEF_MAX_WIDTH);
            he   = clamp_dim(CFG_BITS'(h), MAX_HEIGHT);
            n    = we * he + we + 1;
            kind = $urandom_range(9);
            if (kind == 0) begin
                // broken frame, cut short and abandoned by the next write
                cut = $urandom_range(1, n - 1);
                counted += push_frame_span(we, he, 0, cut);
            end else if (kind == 1) begin
                cut = $urandom_range(1, n - 1);
                counted += push_frame_span(we, he, 0, cut);
                wait_idle();
                write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, $urandom_range(8191));
                counted += push_frame_span(we, he, cut, n);
            end else begin
                repeat ($urandom_range(1, 3))
                    counted += push_frame_span(we, he, 0, n);
            end
        end

        wait_idle();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
